// File: sv/rdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, constants and helpers for the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int VALUE_W    = 32;
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int DIV_BITS   = 8;
    localparam int DIV_STEPS  = VALUE_W / DIV_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_A_OFS = 7'd55;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PUSH,
        ST_READ,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic push;
        logic pop_read;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic quot_zero;
        logic level_zero;
        logic out_free;
    } status_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {1'b0, d};
        if (d < DIGIT_TEN)
            return ext + CHAR_ZERO;
        else
            return ext + CHAR_A_OFS;
    endfunction

endpackage

// File: sv/rdc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rdc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/rdc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_datapath
// Radix register, long-division unit (8 quotient bits a cycle), digit
// stack and output register.
// ----------------------------------------------------------------------------
module rdc_datapath #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rdc_pkg::RADIX_W-1:0]           cfg_wdata,
    input  logic [rdc_pkg::VALUE_W-1:0]           value,
    input  logic                                  out_stall,
    input  rdc_pkg::cmd_t                         cmd,
    output rdc_pkg::status_t                      status,
    output logic                                  out_valid,
    output logic [rdc_pkg::CHAR_W-1:0]            digit_char,
    output logic                                  last_digit
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);

    logic [rdc_pkg::RADIX_W-1:0]  radix_reg, radix_next;
    logic [rdc_pkg::VALUE_W-1:0]  work_reg, work_next;
    logic [rdc_pkg::DIGIT_W-1:0]  rem_reg, rem_next;
    logic [LW-1:0]                level_reg, level_next;
    logic                         out_valid_reg, out_valid_next;
    logic [rdc_pkg::CHAR_W-1:0]   char_reg, char_next;
    logic                         last_reg, last_next;

    logic [rdc_pkg::VALUE_W-1:0]  div_work;
    logic [rdc_pkg::DIGIT_W-1:0]  div_rem;
    logic                         push_ok;
    logic [LW-1:0]                level_dec;
    logic [rdc_pkg::DIGIT_W-1:0]  rd_digit;

    // Eight restoring-division steps: shift dividend bits into the remainder,
    // shift quotient bits into the vacated low end of the work word.
    always_comb
    begin
        logic [rdc_pkg::DIGIT_W:0]   t;
        logic [rdc_pkg::VALUE_W-1:0] w;
        logic [rdc_pkg::DIGIT_W-1:0] r;
        w = work_reg;
        r = rem_reg;
        for (int i = 0; i < rdc_pkg::DIV_BITS; i++)
        begin
            t = {r, w[rdc_pkg::VALUE_W-1]};
            w = {w[rdc_pkg::VALUE_W-2:0], 1'b0};
            if (t >= {1'b0, radix_reg})
            begin
                t    = t - {1'b0, radix_reg};
                w[0] = 1'b1;
            end
            r = t[rdc_pkg::DIGIT_W-1:0];
        end
        div_work = w;
        div_rem  = r;
    end

    assign push_ok   = level_reg < LEVEL_FULL;
    assign level_dec = level_reg - LW'(1);

    always_comb
    begin
        radix_next     = radix_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        // ignore out-of-range radix writes
        if (cfg_we && cfg_wdata >= rdc_pkg::RADIX_MIN && cfg_wdata <= rdc_pkg::RADIX_MAX)
        begin
            radix_next = cfg_wdata;
        end

        if (cmd.load)
        begin
            work_next = value;
            rem_next  = '0;
        end
        if (cmd.div_step)
        begin
            work_next = div_work;
            rem_next  = div_rem;
        end
        if (cmd.push)
        begin
            rem_next = '0;
            if (push_ok)
            begin
                level_next = level_reg + LW'(1);
            end
        end
        if (cmd.pop_read)
        begin
            level_next = level_dec;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            char_next      = rdc_pkg::digit_to_ascii(rd_digit);
            last_next      = (level_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= rdc_pkg::RADIX_RESET;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            radix_reg     <= radix_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    rdc_ram #(
        .WIDTH (rdc_pkg::DIGIT_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (cmd.push && push_ok),
        .waddr (level_reg[AW-1:0]),
        .wdata (rem_reg),
        .re    (cmd.pop_read),
        .raddr (level_dec[AW-1:0]),
        .rdata (rd_digit)
    );

    assign status.quot_zero  = (work_reg == '0);
    assign status.level_zero = (level_reg == '0);
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

endmodule

// File: sv/rdc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer: divide steps per digit, push, then pop and emit digits.
// ----------------------------------------------------------------------------
module rdc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rdc_pkg::status_t   status,
    output rdc_pkg::cmd_t      cmd
);

    rdc_pkg::state_t              state_reg, state_next;
    logic [rdc_pkg::STEP_W-1:0]   step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            rdc_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                begin
                    state_next = rdc_pkg::ST_DIVIDE;
                end
            end
            rdc_pkg::ST_DIVIDE:
            begin
                step_next = step_reg + rdc_pkg::STEP_W'(1);
                if (step_reg == rdc_pkg::STEP_LAST)
                begin
                    state_next = rdc_pkg::ST_PUSH;
                end
            end
            rdc_pkg::ST_PUSH:
            begin
                step_next = '0;
                if (status.quot_zero)
                    state_next = rdc_pkg::ST_READ;
                else
                    state_next = rdc_pkg::ST_DIVIDE;
            end
            rdc_pkg::ST_READ:
            begin
                state_next = rdc_pkg::ST_LOAD;
            end
            rdc_pkg::ST_LOAD:
            begin
                // hold the read digit until the output register frees up
                if (status.out_free)
                begin
                    if (status.level_zero)
                        state_next = rdc_pkg::ST_IDLE;
                    else
                        state_next = rdc_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = rdc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            rdc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            rdc_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            rdc_pkg::ST_PUSH:
            begin
                cmd.push = 1'b1;
            end
            rdc_pkg::ST_READ:
            begin
                cmd.pop_read = 1'b1;
            end
            rdc_pkg::ST_LOAD:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdc_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: sv/radix_digit_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts a 32-bit unsigned value to ASCII digits in a programmable radix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, value): one request per number.
//   Output channel (out_valid / out_stall, digit_char, last_digit): one
//   request per digit, most significant first, last_digit set on the final
//   digit. Zero gives the single digit '0'.
//   cfg_we / cfg_wdata write the radix (2..36); other values are ignored.
//   Write it only while no conversion is in flight.
// Operation:
//   Each digit takes four 8-bit steps of the shared restoring divider plus a
//   stack push; the digits are then read from the stack RAM and loaded into
//   the output register one by one. One number is in work at a time.
//   A new number is taken as soon as the last digit sits in the output
//   register, even while that digit still waits.
// Reset:
//   The radix returns to 10, the stack empties and no digit is valid.
// Stall:
//   A stalled digit holds in the output register; the sequencer waits.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rdc_pkg::RADIX_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rdc_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rdc_pkg::CHAR_W-1:0]    digit_char,
    output logic                          last_digit
);

    rdc_pkg::cmd_t    cmd;
    rdc_pkg::status_t status;

    rdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rdc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .value      (value),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule

// File: dv/tb_radix_digit_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_digit_converter
// Feeds numbers through the radix digit converter under several radix
// settings and checks every emitted digit against a digit-expansion
// predictor. A queue-fed driver sends in random bursts; the digit side
// stalls on its own shifting pattern.
// ----------------------------------------------------------------------------
module tb_radix_digit_converter;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [rdc_pkg::CHAR_W-1:0] ASCII_ZERO = 7'd48;
    localparam logic [rdc_pkg::CHAR_W-1:0] ASCII_A    = 7'd65;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 31;

    typedef struct packed {
        logic [rdc_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } digit_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [rdc_pkg::RADIX_W-1:0]   cfg_wdata = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic [rdc_pkg::VALUE_W-1:0]   value     = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [rdc_pkg::CHAR_W-1:0]    digit_char;
    logic                          last_digit;

    logic [rdc_pkg::VALUE_W-1:0]   pending_values[$];
    digit_t                        expected_digits[$];
    logic [rdc_pkg::RADIX_W-1:0]   radix_now = rdc_pkg::RADIX_RESET;
    int                            mismatches = 0;
    int                            cycle_count = 0;

    int                            burst_left = 0;
    int                            gap_left = 0;
    logic                          next_valid;

    stall_mode_t                   stall_mode = STALL_NONE;
    int                            segment_left = 0;
    logic                          next_stall;
    digit_t                        got_digit;

    radix_digit_converter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Expand a number into its digits, most significant first.
    task automatic expand_digits(input logic [rdc_pkg::VALUE_W-1:0] num,
                                 input logic [rdc_pkg::RADIX_W-1:0] base);
        logic [rdc_pkg::DIGIT_W-1:0] stack [32];
        logic [rdc_pkg::VALUE_W-1:0] rest;
        int                          level;
        digit_t                      d;
        rest  = num;
        level = 0;
        do
        begin
            stack[level] = rdc_pkg::DIGIT_W'(rest % base);
            rest = rest / base;
            level++;
        end while (rest != 0);
        while (level > 0)
        begin
            level--;
            if (stack[level] < 10)
                d.ch = ASCII_ZERO + rdc_pkg::CHAR_W'(stack[level]);
            else
                d.ch = ASCII_A + rdc_pkg::CHAR_W'(stack[level]) - 7'd10;
            d.last = (level == 0);
            expected_digits.push_back(d);
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Driver: bursts of requests separated by random gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            next_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                expand_digits(value, radix_now);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_values.size() > 0)
                begin
                    value <= pending_values.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            in_valid <= next_valid;
        end
    end

    // Monitor: check accepted digits, then pick the next stall value.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_digits.size() == 0)
                report_mismatch($sformatf("unexpected digit 0x%0h last=%0b",
                                          digit_char, last_digit));
            else
            begin
                got_digit = expected_digits.pop_front();
                if (digit_char !== got_digit.ch)
                    report_mismatch($sformatf("digit_char got 0x%0h want 0x%0h",
                                              digit_char, got_digit.ch));
                if (last_digit !== got_digit.last)
                    report_mismatch($sformatf("last_digit got %0b want %0b",
                                              last_digit, got_digit.last));
            end
        end
        if (segment_left == 0)
        begin
            stall_mode   = stall_mode_t'($urandom_range(0, 3));
            segment_left = $urandom_range(8, 120);
        end
        else
            segment_left--;
        case (stall_mode)
            STALL_NONE:   next_stall = 1'b0;
            STALL_LIGHT:  next_stall = ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  next_stall = ($urandom_range(0, 3) != 0);
            STALL_TOGGLE: next_stall = ~out_stall;
            default:      next_stall = 1'b0;
        endcase
        out_stall <= next_stall;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_radix_digit_converter: FAIL");
        $finish;
    end

    // Hold until every queued request is sent and every digit has come back.
    // Sample on the falling edge so the driver's updates have settled.
    task automatic wait_drained();
        while (pending_values.size() != 0 || in_valid || expected_digits.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_radix(input logic [rdc_pkg::RADIX_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (v >= rdc_pkg::RADIX_MIN && v <= rdc_pkg::RADIX_MAX)
            radix_now = v;
    endtask

    function automatic logic [rdc_pkg::RADIX_W-1:0] bad_radix();
        case ($urandom_range(0, 3))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd63;
            default: return rdc_pkg::RADIX_W'($urandom_range(37, 63));
        endcase
    endfunction

    // Mix of full-range, short, tiny and power-boundary numbers.
    function automatic logic [rdc_pkg::VALUE_W-1:0] pick_value(
        input logic [rdc_pkg::RADIX_W-1:0] base);
        logic [63:0] p;
        int          n;
        int          k;
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2:    return $urandom >> $urandom_range(0, 31);
            3:    return $urandom_range(0, 2 * base);
            4:
            begin
                p = 64'd1;
                n = $urandom_range(1, 31);
                for (k = 0; k < n && p * base <= 64'hFFFF_FFFF; k++)
                    p = p * base;
                return rdc_pkg::VALUE_W'(p - $urandom_range(0, 1));
            end
            default: return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
    endfunction

    initial
    begin
        logic [rdc_pkg::RADIX_W-1:0] base;
        int                          ph;
        int                          i;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset radix of ten: zero, single digits, digit rollover, full range.
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(32'd9);
        pending_values.push_back(32'd10);
        pending_values.push_back(32'hFFFF_FFFF);
        wait_drained();

        // Binary: the longest runs.
        write_radix(6'd2);
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        wait_drained();

        // Base 36: letters up to 'Z'.
        write_radix(6'd36);
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd35);
        pending_values.push_back(32'd36);
        pending_values.push_back(32'd1295);
        pending_values.push_back(32'hFFFF_FFFF);
        wait_drained();

        write_radix(6'd16);
        pending_values.push_back(32'hDEAD_BEEF);
        pending_values.push_back(32'h0123_4567);
        wait_drained();

        // Out-of-range writes must leave base 16 in place.
        write_radix(6'd0);
        write_radix(6'd1);
        write_radix(6'd37);
        write_radix(6'd63);
        pending_values.push_back(32'd255);
        wait_drained();

        write_radix(6'd11);
        pending_values.push_back(32'd10);
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 0)
                base = 6'd2;
            else if (ph == 1)
                base = 6'd36;
            else
                base = rdc_pkg::RADIX_W'($urandom_range(2, 36));
            if ($urandom_range(0, 2) == 0)
                write_radix(bad_radix());
            write_radix(base);
            if ($urandom_range(0, 2) == 0)
                write_radix(bad_radix());
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                pending_values.push_back(pick_value(radix_now));
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (expected_digits.size() != 0)
            report_mismatch($sformatf("%0d digits never arrived", expected_digits.size()));
        if (mismatches == 0)
            $display("tb_radix_digit_converter: PASS");
        else
            $display("tb_radix_digit_converter: FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/rdc_pkg.sv
sv/rdc_ram.sv
sv/rdc_datapath.sv
sv/rdc_ctrl.sv
sv/radix_digit_converter.sv
dv/tb_radix_digit_converter.sv
